>>> hw/rtl/s2rc_pkg.sv
// ----------------------------------------------------------------------------
// s2rc_pkg: shared definitions for the signed integer to radix characters block
// Widths, character codes, register indexes, sequencer states and the
// symbol table lookup used by the base checker and the output stage.
// ----------------------------------------------------------------------------
package s2rc_pkg;

    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int VAL_W           = 32;
    localparam int CHAR_W          = 8;
    localparam int LEN_W           = 5;
    localparam int SYM_W           = 64;
    localparam int SYM_IDX_W       = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int MAX_DIGITS      = 32;
    localparam int ND_W            = $clog2(MAX_DIGITS + 1);

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic done;
        logic ok;
    } check_res_t;

    typedef struct packed {
        logic                done;
        logic [VAL_W-1:0]    quotient;
        logic [LEN_W-1:0]    remainder;
    } div_res_t;

    // Symbol byte for a digit value: values 0..7 live in the low word, 8..15 in
    // the high word, lowest value in the lowest byte.
    function automatic logic [CHAR_W-1:0] sym_at(
        input logic [SYM_W-1:0]     lo,
        input logic [SYM_W-1:0]     hi,
        input logic [SYM_IDX_W-1:0] idx
    );
        logic [SYM_W-1:0] w;
        w = idx[3] ? hi : lo;
        return w[{idx[2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

>>> hw/rtl/s2rc_check.sv
// ----------------------------------------------------------------------------
// s2rc_check: digit symbol table checker
// Refuses a length outside 2..MAX_SYMBOLS; walks the symbols in use one per
// cycle, comparing each to the sign characters and every later symbol in use.
// ----------------------------------------------------------------------------
module s2rc_check #(
    parameter int MAX_SYMBOLS = s2rc_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [s2rc_pkg::LEN_W-1:0]      base_length,
    input  logic [s2rc_pkg::SYM_W-1:0]      symbols_low,
    input  logic [s2rc_pkg::SYM_W-1:0]      symbols_high,
    output s2rc_pkg::check_res_t            res
);

    localparam int DIGIT_W = $clog2(MAX_SYMBOLS);

    logic               busy_reg, busy_next;
    logic [DIGIT_W-1:0] idx_reg, idx_next;

    logic                           range_bad;
    logic                           sym_bad;
    logic                           last_sym;
    logic [s2rc_pkg::CHAR_W-1:0]    sym_i;

    always_comb begin
        range_bad = (base_length < s2rc_pkg::LEN_W'(2))
                 || (base_length > s2rc_pkg::LEN_W'(MAX_SYMBOLS));
        sym_i = s2rc_pkg::sym_at(symbols_low, symbols_high,
                                 s2rc_pkg::SYM_IDX_W'(idx_reg));
        sym_bad = (sym_i == s2rc_pkg::PLUS_CHAR) || (sym_i == s2rc_pkg::MINUS_CHAR);
        for (int j = 0; j < MAX_SYMBOLS; j++) begin
            if ((s2rc_pkg::LEN_W'(j) > s2rc_pkg::LEN_W'(idx_reg))
                    && (s2rc_pkg::LEN_W'(j) < base_length)
                    && (s2rc_pkg::sym_at(symbols_low, symbols_high,
                                         s2rc_pkg::SYM_IDX_W'(j)) == sym_i)) begin
                sym_bad = 1'b1;
            end
        end
        last_sym = (s2rc_pkg::LEN_W'(idx_reg) == base_length - s2rc_pkg::LEN_W'(1));

        res.done = busy_reg && (range_bad || sym_bad || last_sym);
        res.ok   = !range_bad && !sym_bad;

        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (start) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (busy_reg) begin
            if (res.done) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + DIGIT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

>>> hw/rtl/s2rc_div.sv
// ----------------------------------------------------------------------------
// s2rc_div: shared radix divider
// Restoring division of a 32-bit magnitude by the base, eight quotient bits
// per cycle.
// ----------------------------------------------------------------------------
module s2rc_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [s2rc_pkg::VAL_W-1:0]      dividend,
    input  logic [s2rc_pkg::LEN_W-1:0]      divisor,
    output s2rc_pkg::div_res_t              res
);

    localparam int STEPS  = 8;
    localparam int CYCLES = s2rc_pkg::VAL_W / STEPS;
    localparam int CNT_W  = $clog2(CYCLES);

    logic                           busy_reg, busy_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [s2rc_pkg::VAL_W-1:0]     dq_reg, dq_next;
    logic [s2rc_pkg::LEN_W-1:0]     rem_reg, rem_next;

    logic [s2rc_pkg::VAL_W-1:0]     dq_step;
    logic [s2rc_pkg::LEN_W-1:0]     rem_step;
    logic [s2rc_pkg::LEN_W:0]       trial;

    always_comb begin
        dq_step  = dq_reg;
        rem_step = rem_reg;
        // The partial remainder stays below the divisor, so the trial value
        // never exceeds twice the largest base.
        for (int k = 0; k < STEPS; k++) begin
            trial = {rem_step, dq_step[s2rc_pkg::VAL_W-1]};
            if (trial >= {1'b0, divisor}) begin
                rem_step = s2rc_pkg::LEN_W'(trial - {1'b0, divisor});
                dq_step  = {dq_step[s2rc_pkg::VAL_W-2:0], 1'b1};
            end else begin
                rem_step = trial[s2rc_pkg::LEN_W-1:0];
                dq_step  = {dq_step[s2rc_pkg::VAL_W-2:0], 1'b0};
            end
        end

        res.done      = busy_reg && (cnt_reg == CNT_W'(CYCLES - 1));
        res.quotient  = dq_step;
        res.remainder = rem_step;

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dq_next   = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            dq_next  = dq_step;
            rem_next = rem_step;
            cnt_next = cnt_reg + CNT_W'(1);
            if (res.done) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
    end

endmodule

>>> hw/rtl/signed_integer_to_radix_chars.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_chars: signed 32-bit number to base-N characters
// Prints each input word as a run of characters in a configurable base,
// minus sign first for negatives, last mark on the final character.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid, s_ready, s_value) takes one signed word at a
// time; s_ready is high only while the block is idle. The output channel
// (m_valid, m_ready, m_character, m_last) carries the characters of each word,
// most significant digit first, m_last high on the final one.
// Configure base_length and the two symbol words through the write port
// while the block is idle. A refused base consumes the word and emits nothing.
// Steps per word: accept, the symbol check (one symbol per cycle), the shared
// divider for each digit (eight quotient bits per cycle), then one character
// per cycle, while the receiver is ready, leaves through the output register.
// When the receiver stalls, the output register holds its character and the
// sequencer waits. Reset clears the registers to zero, so every word is
// refused until a base is written.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_chars #(
    parameter int MAX_SYMBOLS = s2rc_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [s2rc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [s2rc_pkg::SYM_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [s2rc_pkg::VAL_W-1:0]   s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [s2rc_pkg::CHAR_W-1:0]         m_character,
    output logic                                m_last
);

    localparam int DIGIT_W = $clog2(MAX_SYMBOLS);
    localparam int STACK_W = s2rc_pkg::MAX_DIGITS * DIGIT_W;

    logic [s2rc_pkg::LEN_W-1:0]     base_length_reg;
    logic [s2rc_pkg::SYM_W-1:0]     symbols_low_reg;
    logic [s2rc_pkg::SYM_W-1:0]     symbols_high_reg;

    s2rc_pkg::state_t               state_reg, state_next;
    logic [s2rc_pkg::VAL_W-1:0]     mag_reg, mag_next;
    logic                           neg_reg, neg_next;
    logic [STACK_W-1:0]             stack_reg, stack_next;
    logic [s2rc_pkg::ND_W-1:0]      nd_reg, nd_next;
    logic                           m_valid_reg, m_valid_next;
    logic [s2rc_pkg::CHAR_W-1:0]    m_character_reg, m_character_next;
    logic                           m_last_reg, m_last_next;

    logic                           chk_start;
    s2rc_pkg::check_res_t           chk_res;
    logic                           div_start;
    logic [s2rc_pkg::VAL_W-1:0]     div_dividend;
    s2rc_pkg::div_res_t             div_res;
    logic                           out_free;
    logic [s2rc_pkg::ND_W-1:0]      nd_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_length_reg  <= '0;
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
        end else if (cfg_wen) begin
            case (cfg_index)
                s2rc_pkg::REG_BASE_LENGTH: begin
                    base_length_reg <= cfg_wdata[s2rc_pkg::LEN_W-1:0];
                end
                s2rc_pkg::REG_SYMBOLS_LOW: begin
                    symbols_low_reg <= cfg_wdata;
                end
                s2rc_pkg::REG_SYMBOLS_HIGH: begin
                    symbols_high_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    s2rc_check #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (chk_start),
        .base_length  (base_length_reg),
        .symbols_low  (symbols_low_reg),
        .symbols_high (symbols_high_reg),
        .res          (chk_res)
    );

    s2rc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (base_length_reg),
        .res      (div_res)
    );

    assign div_dividend = (state_reg == s2rc_pkg::ST_CHECK) ? mag_reg : div_res.quotient;
    assign out_free     = !m_valid_reg || m_ready;
    assign nd_inc       = nd_reg + s2rc_pkg::ND_W'(1);

    always_comb begin
        state_next       = state_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        stack_next       = stack_reg;
        nd_next          = nd_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_character_next = m_character_reg;
        m_last_next      = m_last_reg;
        chk_start        = 1'b0;
        div_start        = 1'b0;
        s_ready          = 1'b0;

        case (state_reg)
            s2rc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    neg_next   = s_value[s2rc_pkg::VAL_W-1];
                    mag_next   = s_value[s2rc_pkg::VAL_W-1] ? (~s_value + 1'b1) : s_value;
                    chk_start  = 1'b1;
                    state_next = s2rc_pkg::ST_CHECK;
                end
            end
            s2rc_pkg::ST_CHECK: begin
                if (chk_res.done) begin
                    if (chk_res.ok) begin
                        div_start  = 1'b1;
                        nd_next    = '0;
                        state_next = s2rc_pkg::ST_DIV;
                    end else begin
                        state_next = s2rc_pkg::ST_IDLE;
                    end
                end
            end
            s2rc_pkg::ST_DIV: begin
                if (div_res.done) begin
                    // Digits go onto a stack so the last one found leaves first.
                    stack_next = {stack_reg[STACK_W-DIGIT_W-1:0],
                                  div_res.remainder[DIGIT_W-1:0]};
                    nd_next    = nd_inc;
                    if ((div_res.quotient != '0)
                            && (nd_inc < s2rc_pkg::ND_W'(s2rc_pkg::MAX_DIGITS))) begin
                        div_start = 1'b1;
                    end else begin
                        state_next = neg_reg ? s2rc_pkg::ST_SIGN : s2rc_pkg::ST_EMIT;
                    end
                end
            end
            s2rc_pkg::ST_SIGN: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_character_next = s2rc_pkg::MINUS_CHAR;
                    m_last_next      = 1'b0;
                    state_next       = s2rc_pkg::ST_EMIT;
                end
            end
            s2rc_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_character_next = s2rc_pkg::sym_at(symbols_low_reg, symbols_high_reg,
                                           s2rc_pkg::SYM_IDX_W'(stack_reg[DIGIT_W-1:0]));
                    m_last_next      = (nd_reg == s2rc_pkg::ND_W'(1));
                    stack_next       = stack_reg >> DIGIT_W;
                    nd_next          = nd_reg - s2rc_pkg::ND_W'(1);
                    if (nd_reg == s2rc_pkg::ND_W'(1)) begin
                        state_next = s2rc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = s2rc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= s2rc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            nd_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            nd_reg      <= nd_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg         <= mag_next;
        neg_reg         <= neg_next;
        stack_reg       <= stack_next;
        m_character_reg <= m_character_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

endmodule

>>> tb/signed_integer_to_radix_chars_tb.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_chars_tb: self-checking bench for the radix printer
// Drives signed words through the valid/ready input, predicts the character
// run of each word from a shadow copy of the base registers, and compares
// every character and last mark in order. Covers the default refused base,
// decimal, binary, full sixteen-symbol tables, every reason a base is refused,
// and random bases and words with random idles and stalls on both sides.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_chars_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_WORDS = 91;

    // Index 3 is not a register; writes to it must leave the base untouched.
    localparam logic [s2rc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [2*s2rc_pkg::SYM_W-1:0] DEC_SYMBOLS =
        128'h0000_0000_0000_3938_3736_3534_3332_3130;
    localparam logic [2*s2rc_pkg::SYM_W-1:0] HEX_SYMBOLS =
        128'h4645_4443_4241_3938_3736_3534_3332_3130;
    localparam logic [2*s2rc_pkg::SYM_W-1:0] ODD_SYMBOLS =
        128'hF0E1_D2C3_B4A5_9687_7869_5A4B_3C2E_FF00;

    typedef struct {
        logic [s2rc_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } char_t;

    logic                                 aclk      = 1'b0;
    logic                                 aresetn   = 1'b0;
    logic                                 cfg_wen   = 1'b0;
    logic [s2rc_pkg::CFG_IDX_W-1:0]       cfg_index = s2rc_pkg::REG_BASE_LENGTH;
    logic [s2rc_pkg::SYM_W-1:0]           cfg_wdata = '0;
    logic                                 s_valid   = 1'b0;
    logic                                 s_ready;
    logic signed [s2rc_pkg::VAL_W-1:0]    s_value   = '0;
    logic                                 m_valid;
    logic                                 m_ready   = 1'b0;
    logic [s2rc_pkg::CHAR_W-1:0]          m_character;
    logic                                 m_last;

    // Shadow copy of the base registers.
    logic [s2rc_pkg::LEN_W-1:0]           base_len_q = '0;
    logic [s2rc_pkg::SYM_W-1:0]           sym_lo_q   = '0;
    logic [s2rc_pkg::SYM_W-1:0]           sym_hi_q   = '0;

    char_t                    expected_chars[$];
    int                       fail_count  = 0;
    int                       cycle_count = 0;
    int                       out_stall   = 0;
    bit                       calm        = 1'b0;

    signed_integer_to_radix_chars u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void flag_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("cycle %0d: %s", cycle_count, msg);
        end
    endfunction

    function automatic logic [s2rc_pkg::CHAR_W-1:0] digit_symbol(input int d);
        logic [2*s2rc_pkg::SYM_W-1:0] sym_table;
        sym_table = {sym_hi_q, sym_lo_q};
        return sym_table[d*s2rc_pkg::CHAR_W +: s2rc_pkg::CHAR_W];
    endfunction

    function automatic bit radix_usable();
        int                          n;
        logic [s2rc_pkg::CHAR_W-1:0] s;
        n = int'(base_len_q);
        if (n < 2 || n > s2rc_pkg::MAX_SYMBOLS_DEF) begin
            return 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            s = digit_symbol(i);
            if (s == s2rc_pkg::PLUS_CHAR || s == s2rc_pkg::MINUS_CHAR) begin
                return 1'b0;
            end
            for (int j = i + 1; j < n; j++) begin
                if (digit_symbol(j) == s) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Queues the character run that one accepted word must produce.
    function automatic void predict_run(input logic signed [s2rc_pkg::VAL_W-1:0] v);
        logic [s2rc_pkg::VAL_W:0] mag;
        logic [s2rc_pkg::VAL_W:0] radix;
        int                       digits[s2rc_pkg::MAX_DIGITS];
        int                       nd;
        char_t                    c;
        if (!radix_usable()) begin
            return;
        end
        radix = (s2rc_pkg::VAL_W+1)'(base_len_q);
        // A 33-bit magnitude keeps the most negative word exact.
        mag = v[s2rc_pkg::VAL_W-1] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
        nd = 0;
        do begin
            digits[nd] = int'(mag % radix);
            mag = mag / radix;
            nd++;
        end while (mag != 0);
        if (v[s2rc_pkg::VAL_W-1]) begin
            c.ch = s2rc_pkg::MINUS_CHAR;
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        for (int k = nd - 1; k >= 0; k--) begin
            c.ch = digit_symbol(digits[k]);
            c.last = (k == 0);
            expected_chars.push_back(c);
        end
    endfunction

    always @(posedge aclk) begin : check_output
        char_t want;
        if (aresetn && m_valid && m_ready) begin
            out_stall <= calm ? 0 : $urandom_range(0, 5);
            if (expected_chars.size() == 0) begin
                flag_failure($sformatf("unexpected character %02h last %0b",
                                       m_character, m_last));
            end else begin
                want = expected_chars.pop_front();
                if (m_character !== want.ch || m_last !== want.last) begin
                    flag_failure($sformatf("expected %02h last %0b, got %02h last %0b",
                                           want.ch, want.last, m_character, m_last));
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (out_stall > 0) begin
            m_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [s2rc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [s2rc_pkg::SYM_W-1:0] data);
        @(negedge aclk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            s2rc_pkg::REG_BASE_LENGTH:  base_len_q = data[s2rc_pkg::LEN_W-1:0];
            s2rc_pkg::REG_SYMBOLS_LOW:  sym_lo_q = data;
            s2rc_pkg::REG_SYMBOLS_HIGH: sym_hi_q = data;
            default: ;
        endcase
    endtask

    task automatic set_radix(input logic [s2rc_pkg::SYM_W-1:0] len,
                             input logic [2*s2rc_pkg::SYM_W-1:0] syms);
        write_reg(s2rc_pkg::REG_SYMBOLS_LOW, syms[s2rc_pkg::SYM_W-1:0]);
        write_reg(s2rc_pkg::REG_SYMBOLS_HIGH, syms[2*s2rc_pkg::SYM_W-1:s2rc_pkg::SYM_W]);
        write_reg(s2rc_pkg::REG_BASE_LENGTH, len);
    endtask

    // Valid stays high after acceptance so that a back-to-back word needs
    // only one assignment at the next falling edge.
    task automatic send_value(input logic signed [s2rc_pkg::VAL_W-1:0] v);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        predict_run(v);
    endtask

    task automatic hold_until_empty();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
    endtask

    // A refused word leaves nothing to wait for, so allow the block's worst
    // case latency before touching the registers.
    task automatic settle();
        hold_until_empty();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [s2rc_pkg::VAL_W-1:0] draw_value();
        logic [s2rc_pkg::VAL_W-1:0] r;
        case ($urandom_range(0, 5))
            0, 1: r = $urandom;
            2: r = $urandom >> $urandom_range(1, 31);
            3: r = -($urandom >> $urandom_range(1, 31));
            4: r = $urandom_range(0, 40) - 20;
            default: begin
                case ($urandom_range(0, 3))
                    0: r = 32'h8000_0000;
                    1: r = 32'h7FFF_FFFF;
                    2: r = 32'h0000_0000;
                    default: r = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return r;
    endfunction

    // Mostly well-formed tables of distinct symbols; now and then one flaw.
    task automatic random_radix(input int len_pick);
        logic [2*s2rc_pkg::SYM_W-1:0] tbl;
        logic [s2rc_pkg::SYM_W-1:0]   len_word;
        bit                           seen[256];
        int                           b;
        int                           len;
        int                           i;
        int                           j;
        for (i = 0; i < 16; i++) begin
            do b = $urandom_range(0, 255);
            while (seen[b] || b == s2rc_pkg::PLUS_CHAR || b == s2rc_pkg::MINUS_CHAR);
            seen[b] = 1'b1;
            tbl[i*s2rc_pkg::CHAR_W +: s2rc_pkg::CHAR_W] = s2rc_pkg::CHAR_W'(b);
        end
        len = (len_pick > 0) ? len_pick : $urandom_range(2, 16);
        case ($urandom_range(0, 9))
            0: tbl[$urandom_range(0, len - 1)*s2rc_pkg::CHAR_W +: s2rc_pkg::CHAR_W] =
                   $urandom_range(0, 1) ? s2rc_pkg::PLUS_CHAR : s2rc_pkg::MINUS_CHAR;
            1: begin
                i = $urandom_range(1, len - 1);
                j = $urandom_range(0, i - 1);
                tbl[i*s2rc_pkg::CHAR_W +: s2rc_pkg::CHAR_W] =
                    tbl[j*s2rc_pkg::CHAR_W +: s2rc_pkg::CHAR_W];
            end
            2: len = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
            default: ;
        endcase
        len_word = {$urandom, $urandom};
        len_word[s2rc_pkg::LEN_W-1:0] = s2rc_pkg::LEN_W'(len);
        set_radix(len_word, tbl);
    endtask

    task automatic test_reset_base_refused();
        send_value(32'sd0);
        send_value(-32'sd1);
        settle();
    endtask

    task automatic test_decimal();
        set_radix(64'd10, DEC_SYMBOLS);
        send_value(32'sd0);
        send_value(32'sd9);
        send_value(32'sd10);
        send_value(-32'sd1);
        send_value(-32'sd10);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);
        settle();
    endtask

    task automatic test_binary_longest_run();
        set_radix(64'd2, DEC_SYMBOLS);
        send_value(32'sh8000_0000);
        send_value(32'sh7FFF_FFFF);
        settle();
    endtask

    task automatic test_full_tables();
        // Zero and all-ones bytes are plain symbols.
        set_radix(64'd16, ODD_SYMBOLS);
        send_value(32'sd0);
        send_value(-32'sd1);
        send_value(32'sh8000_0000);
        settle();
        // Plus, minus and repeats beyond the used length are ignored.
        set_radix(64'd3, 128'hFFFF_FFFF_FFFF_FFFF_6161_612D_2B63_6261);
        send_value(-32'sd12345);
        settle();
    endtask

    task automatic test_refused_bases();
        set_radix(64'd1, DEC_SYMBOLS);
        send_value(32'sd5);
        settle();
        set_radix(64'd17, HEX_SYMBOLS);
        send_value(32'sd17);
        settle();
        set_radix(64'hFFFF_FFFF_FFFF_FFFF, HEX_SYMBOLS);
        send_value(-32'sd17);
        settle();
        // Only the low five bits of the length write count.
        set_radix(64'hDEAD_BEEF_0000_00EA, DEC_SYMBOLS);
        send_value(-32'sd907);
        settle();
        set_radix(64'd4, 128'h0000_0000_2B32_3130);
        send_value(32'sd7);
        settle();
        set_radix(64'd3, 128'h0000_0000_2B32_3130);
        send_value(32'sd7);
        settle();
        set_radix(64'd16, {8'h2D, HEX_SYMBOLS[2*s2rc_pkg::SYM_W-9:0]});
        send_value(32'sd255);
        settle();
        set_radix(64'd10, {HEX_SYMBOLS[2*s2rc_pkg::SYM_W-1:80], 8'h30, DEC_SYMBOLS[71:0]});
        send_value(32'sd99);
        settle();
        set_radix(64'd10, DEC_SYMBOLS);
        write_reg(REG_UNUSED, '0);
        write_reg(REG_UNUSED, '1);
        send_value(-32'sd42);
        settle();
    endtask

    task automatic test_random_radices();
        int phase;
        int n;
        int counted;
        phase = 0;
        counted = 0;
        while (counted < RANDOM_WORDS) begin
            calm = (phase % 5 == 3);
            random_radix(phase == 0 ? 2 : (phase == 1 ? 16 : 0));
            for (n = 0; n < (radix_usable() ? 13 : 4); n++) begin
                send_value(draw_value());
                if (radix_usable()) begin
                    counted++;
                end
                if (n == 6 && phase % 3 == 1) begin
                    hold_until_empty();
                end
            end
            settle();
            calm = 1'b0;
            phase++;
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_base_refused();
        test_decimal();
        test_binary_longest_run();
        test_full_tables();
        test_refused_bases();
        test_random_radices();
        settle();

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
